// File: rtl/dmtr_pkg.sv
// Shared types, constants and the 5x7 font table of the dot-matrix text rasterizer.
// No dependencies; dmtr_sat_add and the rasterizer unit import this package.
`timescale 1ns / 1ps
`default_nettype none

package dmtr_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int FIELD_W        = 16;
  localparam int SCALE_W        = 8;
  localparam int COLOR_W        = 32;
  localparam int OFF_W          = 12;  // holds 10 * 255

  localparam int GLYPH_COLS     = 5;
  localparam int GLYPH_ROWS     = 7;
  localparam int GLYPH_CELLS    = GLYPH_COLS * GLYPH_ROWS;
  localparam int GLYPH_COUNT    = 44;
  localparam int GLYPH_IDX_W    = $clog2(GLYPH_COUNT);
  localparam int COL_W          = $clog2(GLYPH_COLS);
  localparam int ROW_W          = $clog2(GLYPH_ROWS);

  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [GLYPH_IDX_W-1:0] BLANK_GLYPH = GLYPH_IDX_W'(43);

  typedef logic [GLYPH_CELLS-1:0] glyph_bits_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NEWLINE,
    ST_COLUMN,
    ST_ROW,
    ST_ADVANCE
  } dmtr_state_t;

  // Columns of each glyph, bit 0 is the top row.
  localparam logic [7:0] FONT_ROM [0:GLYPH_COUNT-1][0:GLYPH_COLS-1] = '{
    '{8'd126, 8'd17,  8'd17,  8'd17,  8'd126}, '{8'd127, 8'd73,  8'd73,  8'd73,  8'd54},
    '{8'd62,  8'd65,  8'd65,  8'd65,  8'd34},  '{8'd127, 8'd65,  8'd65,  8'd34,  8'd28},
    '{8'd127, 8'd73,  8'd73,  8'd73,  8'd65},  '{8'd127, 8'd9,   8'd9,   8'd9,   8'd1},
    '{8'd62,  8'd65,  8'd73,  8'd73,  8'd122}, '{8'd127, 8'd8,   8'd8,   8'd8,   8'd127},
    '{8'd0,   8'd65,  8'd127, 8'd65,  8'd0},   '{8'd32,  8'd64,  8'd65,  8'd63,  8'd1},
    '{8'd127, 8'd8,   8'd20,  8'd34,  8'd65},  '{8'd127, 8'd64,  8'd64,  8'd64,  8'd64},
    '{8'd127, 8'd2,   8'd12,  8'd2,   8'd127}, '{8'd127, 8'd4,   8'd8,   8'd16,  8'd127},
    '{8'd62,  8'd65,  8'd65,  8'd65,  8'd62},  '{8'd127, 8'd9,   8'd9,   8'd9,   8'd6},
    '{8'd62,  8'd65,  8'd81,  8'd33,  8'd94},  '{8'd127, 8'd9,   8'd25,  8'd41,  8'd70},
    '{8'd70,  8'd73,  8'd73,  8'd73,  8'd49},  '{8'd1,   8'd1,   8'd127, 8'd1,   8'd1},
    '{8'd63,  8'd64,  8'd64,  8'd64,  8'd63},  '{8'd31,  8'd32,  8'd64,  8'd32,  8'd31},
    '{8'd63,  8'd64,  8'd56,  8'd64,  8'd63},  '{8'd99,  8'd20,  8'd8,   8'd20,  8'd99},
    '{8'd3,   8'd4,   8'd120, 8'd4,   8'd3},   '{8'd97,  8'd81,  8'd73,  8'd69,  8'd67},
    '{8'd62,  8'd81,  8'd73,  8'd69,  8'd62},  '{8'd0,   8'd66,  8'd127, 8'd64,  8'd0},
    '{8'd66,  8'd97,  8'd81,  8'd73,  8'd70},  '{8'd33,  8'd65,  8'd69,  8'd75,  8'd49},
    '{8'd24,  8'd20,  8'd18,  8'd127, 8'd16},  '{8'd39,  8'd69,  8'd69,  8'd69,  8'd57},
    '{8'd60,  8'd74,  8'd73,  8'd73,  8'd48},  '{8'd1,   8'd113, 8'd9,   8'd5,   8'd3},
    '{8'd54,  8'd73,  8'd73,  8'd73,  8'd54},  '{8'd6,   8'd73,  8'd73,  8'd41,  8'd30},
    '{8'd8,   8'd8,   8'd8,   8'd8,   8'd8},   '{8'd0,   8'd96,  8'd96,  8'd0,   8'd0},
    '{8'd0,   8'd54,  8'd54,  8'd0,   8'd0},   '{8'd32,  8'd16,  8'd8,   8'd4,   8'd2},
    '{8'd8,   8'd8,   8'd62,  8'd8,   8'd8},   '{8'd0,   8'd127, 8'd65,  8'd65,  8'd0},
    '{8'd0,   8'd65,  8'd65,  8'd127, 8'd0},   '{8'd0,   8'd0,   8'd0,   8'd0,   8'd0}
  };

  function automatic logic [GLYPH_IDX_W-1:0] glyph_index(input logic [7:0] code);
    logic [7:0] up;
    logic [GLYPH_IDX_W-1:0] idx;
    up = code;
    if (code >= "a" && code <= "z") begin
      up = code - 8'd32;
    end
    if (up >= "A" && up <= "Z") begin
      idx = GLYPH_IDX_W'(up - "A");
    end else if (up >= "0" && up <= "9") begin
      idx = GLYPH_IDX_W'(up - "0") + GLYPH_IDX_W'(26);
    end else begin
      unique case (up)
        "-":     idx = GLYPH_IDX_W'(36);
        ".":     idx = GLYPH_IDX_W'(37);
        ":":     idx = GLYPH_IDX_W'(38);
        "/":     idx = GLYPH_IDX_W'(39);
        "+":     idx = GLYPH_IDX_W'(40);
        "[":     idx = GLYPH_IDX_W'(41);
        "]":     idx = GLYPH_IDX_W'(42);
        default: idx = BLANK_GLYPH;
      endcase
    end
    return idx;
  endfunction

  // Flatten a glyph in scan order: column major, top row first.
  function automatic glyph_bits_t glyph_bits(input logic [7:0] code);
    logic [GLYPH_IDX_W-1:0] idx;
    glyph_bits_t bits;
    idx = glyph_index(code);
    for (int c = 0; c < GLYPH_COLS; c++) begin
      for (int r = 0; r < GLYPH_ROWS; r++) begin
        bits[c*GLYPH_ROWS + r] = FONT_ROM[idx][c][r];
      end
    end
    return bits;
  endfunction

endpackage

`default_nettype wire

// File: rtl/dmtr_in_if.sv
// Character word channel of the dot-matrix text rasterizer.
// Depends on nothing; valid/ready handshake with the character payload.
`timescale 1ns / 1ps
`default_nettype none

interface dmtr_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  char_code;
  logic        new_string;
  logic [15:0] origin_x;
  logic [15:0] origin_y;
  logic [31:0] color_rgba;

  modport source (output valid, char_code, new_string, origin_x, origin_y, color_rgba,
                  input ready);
  modport sink   (input valid, char_code, new_string, origin_x, origin_y, color_rgba,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/dmtr_out_if.sv
// Pixel cell word channel of the dot-matrix text rasterizer.
// Depends on nothing; valid/ready handshake with the cell payload.
`timescale 1ns / 1ps
`default_nettype none

interface dmtr_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] pixel_x;
  logic [15:0] pixel_y;
  logic [31:0] cell_color;
  logic        last_cell;

  modport source (output valid, pixel_x, pixel_y, cell_color, last_cell, input ready);
  modport sink   (input valid, pixel_x, pixel_y, cell_color, last_cell, output ready);
endinterface

`default_nettype wire

// File: rtl/dmtr_sat_add.sv
// Shared saturating adder: coordinate plus small offset, clamped at all ones.
// Uses dmtr_pkg for the offset width.
`timescale 1ns / 1ps
`default_nettype none

module dmtr_sat_add
  import dmtr_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic [COORD_BITS-1:0] base,
  input  wire logic [OFF_W-1:0]      offset,
  output logic      [COORD_BITS-1:0] sum
);

  logic [COORD_BITS:0] raw;

  assign raw = {1'b0, base} + (COORD_BITS+1)'(offset);
  assign sum = raw[COORD_BITS] ? '1 : raw[COORD_BITS-1:0];

endmodule

`default_nettype wire

// File: rtl/dot_matrix_text_rasterizer_unit.sv
// Dot-matrix text rasterizer: one character word in, one word per lit 5x7 font cell out.
//
// in_ch  (sink):   char_code, new_string, origin_x/y (Q12.4), color_rgba.
// out_ch (source): pixel_x/y of the cell's top-left corner (Q12.4, saturated), cell_color
//                  and last_cell on the final lit cell of the character.
// cfg_we/cfg_wdata write cell_scale (Q4.4); write it only while the block is idle.
//
// A character is accepted when in_ch.ready is high, i.e. when the sequencer is idle.
// A glyph is then walked column by column: one step forms x, seven row steps scan the
// column, and a final step advances the cursor; the one shared saturating adder serves each
// step. A newline emits nothing and moves the cursor down to the line start; unknown codes
// emit nothing but still walk the blank glyph. Words form via COLUMN, ROW, output register.
// Cell words sit in an output register; when the receiver stalls with a word pending,
// the scan holds at the next lit cell until the register frees.
// Reset (rst_n low, synchronous) returns the sequencer to idle, clears cursor, line start
// and output valid and loads cell_scale with 1.0.
`timescale 1ns / 1ps
`default_nettype none

module dot_matrix_text_rasterizer_unit
  import dmtr_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  dmtr_in_if.sink                 in_ch,
  dmtr_out_if.source              out_ch,
  input  wire logic               cfg_we,
  input  wire logic [SCALE_W-1:0] cfg_wdata
);

  localparam logic [COORD_BITS-1:0] CMAX = '1;

  dmtr_state_t           state_r, state_nxt;
  logic [SCALE_W-1:0]    scale_r;
  logic [COORD_BITS-1:0] cursor_x_r, cursor_x_nxt;
  logic [COORD_BITS-1:0] cursor_y_r, cursor_y_nxt;
  logic [COORD_BITS-1:0] line_x_r, line_x_nxt;
  logic [COLOR_W-1:0]    color_r, color_nxt;
  glyph_bits_t           glyph_r, glyph_nxt;
  logic [ROW_W-1:0]      row_r, row_nxt;
  logic [COL_W-1:0]      col_r, col_nxt;
  logic [OFF_W-1:0]      row_off_r, row_off_nxt;
  logic [OFF_W-1:0]      col_off_r, col_off_nxt;
  logic [COORD_BITS-1:0] px_r, px_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [COORD_BITS-1:0] out_x_r, out_x_nxt;
  logic [COORD_BITS-1:0] out_y_r, out_y_nxt;
  logic [COLOR_W-1:0]    out_color_r, out_color_nxt;
  logic                  out_last_r, out_last_nxt;

  logic [COORD_BITS-1:0] add_a, add_sum;
  logic [OFF_W-1:0]      add_b;
  logic [OFF_W-1:0]      scale_ext, adv_off, line_off;
  logic [COORD_BITS-1:0] org_x, org_y;
  logic                  out_free;

  assign scale_ext = OFF_W'(scale_r);
  assign adv_off   = (scale_ext << 2) + (scale_ext << 1);
  assign line_off  = (scale_ext << 3) + (scale_ext << 1);

  assign org_x = (33'(in_ch.origin_x) > 33'(CMAX)) ? CMAX : COORD_BITS'(in_ch.origin_x);
  assign org_y = (33'(in_ch.origin_y) > 33'(CMAX)) ? CMAX : COORD_BITS'(in_ch.origin_y);

  assign out_free = !out_valid_r || out_ch.ready;

  dmtr_sat_add #(
    .COORD_BITS (COORD_BITS)
  ) u_add (
    .base   (add_a),
    .offset (add_b),
    .sum    (add_sum)
  );

  assign in_ch.ready       = (state_r == ST_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.pixel_x    = FIELD_W'(out_x_r);
  assign out_ch.pixel_y    = FIELD_W'(out_y_r);
  assign out_ch.cell_color = out_color_r;
  assign out_ch.last_cell  = out_last_r;

  always_comb begin
    unique case (state_r)
      ST_NEWLINE: begin add_a = cursor_y_r; add_b = line_off;  end
      ST_COLUMN:  begin add_a = cursor_x_r; add_b = col_off_r; end
      ST_ROW:     begin add_a = cursor_y_r; add_b = row_off_r; end
      ST_ADVANCE: begin add_a = cursor_x_r; add_b = adv_off;   end
      default:    begin add_a = cursor_x_r; add_b = '0;        end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    cursor_x_nxt  = cursor_x_r;
    cursor_y_nxt  = cursor_y_r;
    line_x_nxt    = line_x_r;
    color_nxt     = color_r;
    glyph_nxt     = glyph_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    row_off_nxt   = row_off_r;
    col_off_nxt   = col_off_r;
    px_nxt        = px_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_color_nxt = out_color_r;
    out_last_nxt  = out_last_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          if (in_ch.new_string) begin
            cursor_x_nxt = org_x;
            line_x_nxt   = org_x;
            cursor_y_nxt = org_y;
          end
          color_nxt   = in_ch.color_rgba;
          glyph_nxt   = glyph_bits(in_ch.char_code);
          col_nxt     = '0;
          col_off_nxt = '0;
          state_nxt   = (in_ch.char_code == NEWLINE_CODE) ? ST_NEWLINE : ST_COLUMN;
        end
      end
      ST_NEWLINE: begin
        cursor_x_nxt = line_x_r;
        cursor_y_nxt = add_sum;
        state_nxt    = ST_IDLE;
      end
      ST_COLUMN: begin
        px_nxt      = add_sum;
        row_nxt     = '0;
        row_off_nxt = '0;
        state_nxt   = ST_ROW;
      end
      ST_ROW: begin
        // hold on a lit cell until the output register frees
        if (!glyph_r[0] || out_free) begin
          if (glyph_r[0]) begin
            out_valid_nxt = 1'b1;
            out_x_nxt     = px_r;
            out_y_nxt     = add_sum;
            out_color_nxt = color_r;
            out_last_nxt  = (glyph_r[GLYPH_CELLS-1:1] == '0);
          end
          glyph_nxt   = glyph_r >> 1;
          row_nxt     = row_r + 1'b1;
          row_off_nxt = row_off_r + scale_ext;
          if (row_r == ROW_W'(GLYPH_ROWS-1)) begin
            col_nxt     = col_r + 1'b1;
            col_off_nxt = col_off_r + scale_ext;
            state_nxt   = (col_r == COL_W'(GLYPH_COLS-1)) ? ST_ADVANCE : ST_COLUMN;
          end
        end
      end
      ST_ADVANCE: begin
        cursor_x_nxt = add_sum;
        state_nxt    = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      scale_r     <= SCALE_W'(16);
      cursor_x_r  <= '0;
      cursor_y_r  <= '0;
      line_x_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cursor_x_r  <= cursor_x_nxt;
      cursor_y_r  <= cursor_y_nxt;
      line_x_r    <= line_x_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        scale_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    color_r     <= color_nxt;
    glyph_r     <= glyph_nxt;
    row_r       <= row_nxt;
    col_r       <= col_nxt;
    row_off_r   <= row_off_nxt;
    col_off_r   <= col_off_nxt;
    px_r        <= px_nxt;
    out_x_r     <= out_x_nxt;
    out_y_r     <= out_y_nxt;
    out_color_r <= out_color_nxt;
    out_last_r  <= out_last_nxt;
  end

endmodule

`default_nettype wire
